// ===== hw/rtl/ffe_pkg.sv =====
// Shared definitions for the fire effect frame engine: item function codes,
// the command word from the controller to the datapath and the colour ramp
// thresholds. No dependencies.
package ffe_pkg;

    localparam logic [1:0] FUNC_SEED    = 2'd0;
    localparam logic [1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;

    localparam logic [7:0] HEAT_LOW  = 8'd64;
    localparam logic [7:0] HEAT_MID  = 8'd128;
    localparam logic [7:0] HEAT_HIGH = 8'd192;
    localparam logic [8:0] COLOUR_ONE = 9'd256;
    // floor(x / 3) == (x * 683) >> 11 for every x below 2048.
    localparam logic [10:0] THIRD_RECIP = 11'd683;
    localparam int          THIRD_SHIFT = 11;

    localparam logic [7:0] DECAY_RESET = 8'd2;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_SEED,
        CMD_READ,
        CMD_ADV
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      p_load;
        logic      out_load;
    } cmd_t;

endpackage

// ===== hw/rtl/ffe_ctrl.sv =====
// Controller of the fire effect frame engine: the sequencer for the clearing
// pass and the frame advance, and the valid bits of the result pipeline.
// Depends on ffe_pkg.
module ffe_ctrl #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64,
    parameter int AW          = 12,
    parameter int CW          = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        func,
    output logic              m_tvalid,
    input  logic              m_tready,
    output ffe_pkg::cmd_t     cmd,
    output logic [AW-1:0]     cmd_addr,
    output logic [CW-1:0]     cmd_col
);
    import ffe_pkg::*;

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
    localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] LAST_ADV  = AW'((GRID_HEIGHT - 1) * GRID_WIDTH - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(GRID_WIDTH - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADV,
        ST_DRAIN
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [CW-1:0] col_reg, col_next;
    logic          p_valid_reg, p_valid_next;
    logic          m_valid_reg, m_valid_next;
    logic          out_free;
    logic          out_load;
    logic          accept;

    assign out_free = !m_valid_reg || m_tready;
    assign out_load = p_valid_reg && out_free;
    assign s_tready = (state_reg == ST_IDLE) && (!p_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign cmd_addr = addr_reg;
    assign cmd_col  = col_reg;

    always_comb begin
        cmd.p_load   = accept;
        cmd.out_load = out_load;
        cmd.kind     = CMD_NONE;
        unique case (state_reg)
            ST_CLEAR: cmd.kind = CMD_CLEAR;
            ST_ADV:   cmd.kind = CMD_ADV;
            ST_IDLE: begin
                if (accept && func == FUNC_SEED) begin
                    cmd.kind = CMD_SEED;
                end else if (accept && func == FUNC_READ) begin
                    cmd.kind = CMD_READ;
                end
            end
            default:  cmd.kind = CMD_NONE;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        col_next   = col_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                addr_next = addr_reg + AW'(1);
                if (addr_reg == LAST_CELL) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && func == FUNC_ADVANCE) begin
                    addr_next  = '0;
                    col_next   = '0;
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                addr_next = addr_reg + AW'(1);
                col_next  = (col_reg == LAST_COL) ? '0 : col_reg + CW'(1);
                if (addr_reg == LAST_ADV) begin
                    state_next = ST_DRAIN;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        p_valid_next = p_valid_reg;
        if (accept) begin
            p_valid_next = 1'b1;
        end else if (out_load) begin
            p_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            col_reg     <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            col_reg     <= col_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_adv_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && func == FUNC_ADVANCE) |=> (state_reg == ST_ADV && !s_tready))
        else $error("advance item did not start the frame sweep");

    a_drain_after_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> $past(state_reg == ST_ADV && addr_reg == LAST_ADV))
        else $error("drain entered without finishing the sweep");

    a_pending_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid_reg && !m_valid_reg) |=> m_valid_reg)
        else $error("pending result not moved to the output register");

endmodule

// ===== hw/rtl/ffe_dp.sv =====
// Datapath of the fire effect frame engine: the heat grid memory with two
// read ports, the sliding window of the frame update, the decay register and
// the result registers with the colour ramp. Depends on ffe_pkg.
module ffe_dp #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64,
    parameter int AW          = 12,
    parameter int CW          = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffe_pkg::cmd_t     cmd,
    input  logic [AW-1:0]     cmd_addr,
    input  logic [CW-1:0]     cmd_col,
    input  logic [5:0]        column,
    input  logic [5:0]        row,
    input  logic [7:0]        seed_heat,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    output logic [7:0]        heat,
    output logic [8:0]        red,
    output logic [8:0]        green,
    output logic [8:0]        blue
);
    import ffe_pkg::*;

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;

    logic [7:0]    mem [0:CELL_COUNT-1];
    logic [7:0]    q_self, q_low;
    logic [7:0]    decay_reg;

    logic          rd_adv_reg;
    logic [CW-1:0] rd_col_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [7:0]    s1_reg, l1_reg, l2_reg;
    logic          p_read_reg;
    logic [7:0]    heat_reg;
    logic [8:0]    red_reg, green_reg, blue_reg;

    logic          col_ok, row_ok;
    logic [AW-1:0] item_addr, seed_addr;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic          re_a, re_b;
    logic          adv_we;
    logic [9:0]    sum;
    logic [7:0]    avg, cooled;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [9:0]    heat_x4;
    logic [20:0]   third_prod;
    logic [7:0]    heat_next;
    logic [8:0]    red_next, green_next, blue_next;

    assign col_ok    = (32'(column) < 32'(GRID_WIDTH));
    assign row_ok    = (32'(row) < 32'(GRID_HEIGHT));
    assign item_addr = AW'(int'(row) * GRID_WIDTH + int'(column));
    assign seed_addr = AW'((GRID_HEIGHT - 1) * GRID_WIDTH + int'(column));

    // During a sweep port A reads the cell itself and port B the cell below.
    assign re_a      = (cmd.kind == CMD_ADV) || (cmd.kind == CMD_READ && col_ok && row_ok);
    assign re_b      = (cmd.kind == CMD_ADV);
    assign rd_addr_a = (cmd.kind == CMD_READ) ? item_addr : cmd_addr;
    assign rd_addr_b = cmd_addr + AW'(GRID_WIDTH);

    // Data for column k is back: the window then covers column k-1, which
    // is written unless it is an edge column.
    assign adv_we = rd_adv_reg && (rd_col_reg >= CW'(2));
    assign sum    = 10'(s1_reg) + 10'(l2_reg) + 10'(l1_reg) + 10'(q_low);
    assign avg    = sum[9:2];
    assign cooled = (avg > decay_reg) ? avg - decay_reg : 8'd0;

    always_comb begin
        we    = 1'b0;
        waddr = cmd_addr;
        wdata = 8'd0;
        priority if (adv_we) begin
            we    = 1'b1;
            waddr = rd_addr_reg - AW'(1);
            wdata = cooled;
        end else if (cmd.kind == CMD_CLEAR) begin
            we    = 1'b1;
        end else if (cmd.kind == CMD_SEED && col_ok) begin
            we    = 1'b1;
            waddr = seed_addr;
            wdata = seed_heat;
        end else begin
            we    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re_a) begin
            q_self <= mem[rd_addr_a];
        end
        if (re_b) begin
            q_low <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_adv_reg <= 1'b0;
            decay_reg  <= DECAY_RESET;
            p_read_reg <= 1'b0;
        end else begin
            rd_adv_reg <= (cmd.kind == CMD_ADV);
            if (cfg_we) begin
                decay_reg <= cfg_wdata;
            end
            if (cmd.p_load) begin
                p_read_reg <= (cmd.kind == CMD_READ) && col_ok && row_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_col_reg  <= cmd_col;
        rd_addr_reg <= cmd_addr;
        if (rd_adv_reg) begin
            l2_reg <= l1_reg;
            l1_reg <= q_low;
            s1_reg <= q_self;
        end
    end

    assign heat_x4    = {q_self, 2'b00};
    assign third_prod = 21'(heat_x4) * 21'(THIRD_RECIP);

    always_comb begin
        heat_next  = 8'd0;
        red_next   = 9'd0;
        green_next = 9'd0;
        blue_next  = 9'd0;
        if (p_read_reg) begin
            heat_next = q_self;
            priority if (q_self < HEAT_LOW) begin
                red_next   = heat_x4[8:0];
            end else if (q_self < HEAT_MID) begin
                red_next   = COLOUR_ONE;
                green_next = {q_self, 1'b0};
            end else if (q_self < HEAT_HIGH) begin
                red_next   = COLOUR_ONE;
                green_next = COLOUR_ONE;
                blue_next  = third_prod[THIRD_SHIFT +: 9];
            end else begin
                red_next   = COLOUR_ONE;
                green_next = COLOUR_ONE;
                blue_next  = COLOUR_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            heat_reg  <= heat_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign heat  = heat_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    a_sweep_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.kind == CMD_ADV) |=> rd_adv_reg)
        else $error("sweep read did not reach the window stage");

    a_write_port_free: assert property (@(posedge aclk) disable iff (!aresetn)
        adv_we |-> !(cmd.kind == CMD_SEED || cmd.kind == CMD_CLEAR))
        else $error("frame update write collides with another write");

    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && !p_read_reg) |=> (heat_reg == 8'd0 && red_reg == 9'd0 &&
                                           blue_reg == 9'd0))
        else $error("non-read item produced a nonzero result");

endmodule

// ===== hw/rtl/fire_effect_frame_engine_top.sv =====
// Top level of the fire effect frame engine: stream ports, field packing and
// the controller and datapath instances. Depends on ffe_pkg, ffe_ctrl, ffe_dp.
//
// Seed writes, cell reads and unused codes are accepted back to back while
// the output is not stalled; each gives one result through a pending stage
// and an output register. An advance item gives its zero result the same
// way but then holds s_tready low while the sequencer sweeps every row but
// the bottom one from the top, one cell per cycle, reading each cell and the
// cell below it through the two read ports of the grid memory and writing
// the update of all but the edge columns in place. After reset a clearing
// pass zeroes the grid before the first item is accepted; configuration
// writes are taken at any time.
module fire_effect_frame_engine_top #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // column[5:0], row[11:6], seed_heat[19:12], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // heat[7:0], red[16:8], green[25:17], blue[34:26], pad
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata  // decay
);
    import ffe_pkg::*;

    localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT);
    localparam int CW = $clog2(GRID_WIDTH);

    cmd_t          cmd;
    logic [AW-1:0] cmd_addr;
    logic [CW-1:0] cmd_col;
    logic [7:0]    heat;
    logic [8:0]    red, green, blue;

    ffe_ctrl #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .func    (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd),
        .cmd_addr(cmd_addr),
        .cmd_col (cmd_col)
    );

    ffe_dp #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT),
        .AW         (AW),
        .CW         (CW)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cmd_addr (cmd_addr),
        .cmd_col  (cmd_col),
        .column   (s_tdata[5:0]),
        .row      (s_tdata[11:6]),
        .seed_heat(s_tdata[19:12]),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .heat     (heat),
        .red      (red),
        .green    (green),
        .blue     (blue)
    );

    assign m_tdata = {5'd0, blue, green, red, heat};

endmodule
